FILE: hw/rtl/rep_string_move_fill_sequencer_macros.svh
// Assertion helpers for the string sequencer.
`ifndef REP_STRING_MOVE_FILL_SEQUENCER_MACROS_SVH
`define REP_STRING_MOVE_FILL_SEQUENCER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RSMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsmf: implication check failed");

// Condition must never hold.
`define RSMF_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rsmf: forbidden condition seen");

`endif

FILE: hw/rtl/rsmf_pkg.sv
`timescale 1ns / 1ps

package rsmf_pkg;

  localparam int DATA_W = 16;
  localparam int ADDR_W = 20;

  localparam logic [1:0] REQ_START      = 2'd0;
  localparam logic [1:0] REQ_READ_DONE  = 2'd1;
  localparam logic [1:0] REQ_WRITE_DONE = 2'd2;
  localparam logic [1:0] REQ_UNUSED     = 2'd3;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;
  localparam logic [1:0] ACT_FAULT = 2'd3;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_RD_DONE,
    KIND_WR_DONE
  } kind_t;

  // Queue entry handed from front to back.
  typedef struct packed {
    kind_t             kind;
    logic              is_fill;
    logic              is_word;
    logic              dir_down;
    logic [DATA_W-1:0] src_segment;
    logic [DATA_W-1:0] dst_segment;
    logic [DATA_W-1:0] src_offset;
    logic [DATA_W-1:0] dst_offset;
    logic [DATA_W-1:0] elem_count;
    logic [DATA_W-1:0] data;      // masked fill value on a fill start, zero on a copy start, raw read data otherwise
    logic              fault;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] lin_addr(input logic [DATA_W-1:0] seg,
                                                 input logic [DATA_W-1:0] off);
    lin_addr = {seg, 4'b0000} + {4'b0000, off};
  endfunction

  function automatic logic [DATA_W-1:0] step_off(input logic [DATA_W-1:0] off,
                                                 input logic word,
                                                 input logic down);
    logic [DATA_W-1:0] w;
    w = word ? DATA_W'(2) : DATA_W'(1);
    step_off = down ? off - w : off + w;
  endfunction

  function automatic logic [DATA_W-1:0] mask_data(input logic [DATA_W-1:0] d,
                                                  input logic word);
    mask_data = word ? d : {8'h00, d[7:0]};
  endfunction

endpackage

FILE: hw/rtl/rsmf_if.sv
`timescale 1ns / 1ps

interface rsmf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        is_fill;
  logic        is_word;
  logic        dir_down;
  logic [15:0] src_segment;
  logic [15:0] dst_segment;
  logic [15:0] src_offset;
  logic [15:0] dst_offset;
  logic [15:0] elem_count;
  logic [15:0] fill_value;
  logic [15:0] read_data;
  logic        fault;

  modport source (
    output valid, req_type, is_fill, is_word, dir_down, src_segment, dst_segment,
    output src_offset, dst_offset, elem_count, fill_value, read_data, fault,
    input  ready
  );
  modport sink (
    input  valid, req_type, is_fill, is_word, dir_down, src_segment, dst_segment,
    input  src_offset, dst_offset, elem_count, fill_value, read_data, fault,
    output ready
  );
endinterface

interface rsmf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [19:0] linear_address;
  logic        access_word;
  logic [15:0] write_data;
  logic [15:0] cur_src_offset;
  logic [15:0] cur_dst_offset;
  logic [15:0] remaining;

  modport source (
    output valid, action, linear_address, access_word, write_data,
    output cur_src_offset, cur_dst_offset, remaining,
    input  ready
  );
  modport sink (
    input  valid, action, linear_address, access_word, write_data,
    input  cur_src_offset, cur_dst_offset, remaining,
    output ready
  );
endinterface

FILE: hw/rtl/rsmf_front.sv
`timescale 1ns / 1ps

module rsmf_front
  import rsmf_pkg::*;
(
  rsmf_in_if.sink cmd,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_entry
);

  always_comb begin
    q_entry             = '0;
    q_entry.is_fill     = cmd.is_fill;
    q_entry.is_word     = cmd.is_word;
    q_entry.dir_down    = cmd.dir_down;
    q_entry.src_segment = cmd.src_segment;
    q_entry.dst_segment = cmd.dst_segment;
    q_entry.src_offset  = cmd.src_offset;
    q_entry.dst_offset  = cmd.dst_offset;
    q_entry.elem_count  = cmd.elem_count;
    q_entry.fault       = cmd.fault;
    unique case (cmd.req_type)
      REQ_START: begin
        q_entry.kind = KIND_START;
        q_entry.data = cmd.is_fill ? mask_data(cmd.fill_value, cmd.is_word) : '0;
      end
      REQ_READ_DONE: begin
        q_entry.kind = KIND_RD_DONE;
        q_entry.data = cmd.read_data;
      end
      REQ_WRITE_DONE: begin
        q_entry.kind = KIND_WR_DONE;
        q_entry.data = cmd.read_data;
      end
      default: begin
        q_entry.kind = KIND_START;
        q_entry.data = '0;
      end
    endcase
  end

  // unused request codes are taken and dropped here
  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full && (cmd.req_type != REQ_UNUSED);

endmodule

FILE: hw/rtl/rsmf_queue.sv
`timescale 1ns / 1ps

module rsmf_queue
  import rsmf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_entry,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        store[wr_ptr] <= push_entry;
        wr_ptr        <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rsmf_back.sv
`timescale 1ns / 1ps

module rsmf_back
  import rsmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  rsmf_out_if.source  res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE
  } phase_t;

  phase_t            phase, phase_next;
  logic              mode_fill, mode_fill_next;
  logic              mode_word, mode_word_next;
  logic              dir_flag, dir_flag_next;
  logic [DATA_W-1:0] src_seg_reg, src_seg_next;
  logic [DATA_W-1:0] dst_seg_reg, dst_seg_next;
  logic [DATA_W-1:0] src_off_reg, src_off_next;
  logic [DATA_W-1:0] dst_off_reg, dst_off_next;
  logic [DATA_W-1:0] count_reg, count_next;
  logic [DATA_W-1:0] data_reg, data_next;
  logic              emit;
  logic [1:0]        act;
  logic              out_free;

  assign out_free = !res.valid || res.ready;
  assign q_pop    = q_valid && out_free;

  always_comb begin
    phase_next     = phase;
    mode_fill_next = mode_fill;
    mode_word_next = mode_word;
    dir_flag_next  = dir_flag;
    src_seg_next   = src_seg_reg;
    dst_seg_next   = dst_seg_reg;
    src_off_next   = src_off_reg;
    dst_off_next   = dst_off_reg;
    count_next     = count_reg;
    data_next      = data_reg;
    emit           = 1'b0;
    act            = ACT_DONE;
    if (q_pop) begin
      unique case (q_head.kind)
        KIND_START: begin
          mode_fill_next = q_head.is_fill;
          mode_word_next = q_head.is_word;
          dir_flag_next  = q_head.dir_down;
          src_seg_next   = q_head.src_segment;
          dst_seg_next   = q_head.dst_segment;
          src_off_next   = q_head.src_offset;
          dst_off_next   = q_head.dst_offset;
          count_next     = q_head.elem_count;
          data_next      = q_head.data;
          emit           = 1'b1;
        end
        KIND_RD_DONE: begin
          if (phase == PH_READ) begin
            emit = 1'b1;
            if (q_head.fault) begin
              act = ACT_FAULT;
            end else begin
              act       = ACT_WRITE;
              data_next = mask_data(q_head.data, mode_word);
            end
          end
        end
        KIND_WR_DONE: begin
          if (phase == PH_WRITE) begin
            emit = 1'b1;
            if (q_head.fault) begin
              act = ACT_FAULT;
            end else begin
              if (!mode_fill) begin
                src_off_next = step_off(src_off_reg, mode_word, dir_flag);
              end
              dst_off_next = step_off(dst_off_reg, mode_word, dir_flag);
              count_next   = count_reg - 1'b1;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      // start and clean write completion both issue the next access, or done at zero count
      if (emit && (q_head.kind == KIND_START ||
                   (q_head.kind == KIND_WR_DONE && !q_head.fault))) begin
        if (count_next == '0) begin
          act = ACT_DONE;
        end else if (mode_fill_next) begin
          act = ACT_WRITE;
        end else begin
          act = ACT_READ;
        end
      end
      if (emit) begin
        unique case (act)
          ACT_READ:  phase_next = PH_READ;
          ACT_WRITE: phase_next = PH_WRITE;
          default:   phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      res.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_free) begin
        res.valid <= emit;
      end
    end
    mode_fill   <= mode_fill_next;
    mode_word   <= mode_word_next;
    dir_flag    <= dir_flag_next;
    src_seg_reg <= src_seg_next;
    dst_seg_reg <= dst_seg_next;
    src_off_reg <= src_off_next;
    dst_off_reg <= dst_off_next;
    count_reg   <= count_next;
    data_reg    <= data_next;
    if (emit) begin
      res.action         <= act;
      res.linear_address <= '0;
      res.access_word    <= 1'b0;
      res.write_data     <= '0;
      if (act == ACT_READ) begin
        res.linear_address <= lin_addr(src_seg_next, src_off_next);
        res.access_word    <= mode_word_next;
      end else if (act == ACT_WRITE) begin
        res.linear_address <= lin_addr(dst_seg_next, dst_off_next);
        res.access_word    <= mode_word_next;
        res.write_data     <= data_next;
      end
      res.cur_src_offset <= src_off_next;
      res.cur_dst_offset <= dst_off_next;
      res.remaining      <= count_next;
    end
  end

endmodule

FILE: hw/rtl/rep_string_move_fill_sequencer.sv
`timescale 1ns / 1ps
// Channel | Dir | Contents
// cmd     | in  | start command, read completion or write completion
// res     | out | read/write request, done or fault stop, with offsets and count
//
// One transaction per cycle on each side while neither side stalls; a command is queued
// when taken; its result, if any, goes into the output register once that is free.
// Rate is set by the back end stepping one queued command per cycle while res is not stalled.
// Reset: one cycle of rst, sequencer idle, queue empty; no clearing pass.
// cmd stalls only when the QUEUE_DEPTH-entry queue is full; res stalls hold the
// output register while the queue keeps filling.

`include "rep_string_move_fill_sequencer_macros.svh"

module rep_string_move_fill_sequencer
  import rsmf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  rsmf_in_if.sink    cmd,
  rsmf_out_if.source res
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_entry;
  cmd_t q_head;
  logic unused_cmd;
  logic res_stop;
  logic res_blank;

  assign unused_cmd = cmd.valid && (cmd.req_type == REQ_UNUSED);
  assign res_stop   = res.valid && (res.action == ACT_DONE || res.action == ACT_FAULT);
  assign res_blank  = (res.linear_address == '0) && (res.write_data == '0);

  rsmf_front u_front (
    .cmd     (cmd),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  rsmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  rsmf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

  `RSMF_ASSERT_NEVER(a_push_when_full, clk, rst, q_push && q_full)
  `RSMF_ASSERT_NEVER(a_pop_when_empty, clk, rst, q_pop && !q_valid)
  `RSMF_ASSERT_IMPL(a_unused_dropped, clk, rst, unused_cmd, !q_push)
  `RSMF_ASSERT_IMPL(a_stop_no_addr, clk, rst, res_stop, res_blank)

endmodule

FILE: verif/rep_string_move_fill_sequencer_tb.sv
`timescale 1ns / 1ps

module rep_string_move_fill_sequencer_tb;
  import rsmf_pkg::*;

  typedef struct {
    logic [1:0]  req_type;
    logic        is_fill;
    logic        is_word;
    logic        dir_down;
    logic [15:0] src_segment;
    logic [15:0] dst_segment;
    logic [15:0] src_offset;
    logic [15:0] dst_offset;
    logic [15:0] elem_count;
    logic [15:0] fill_value;
    logic [15:0] read_data;
    logic        fault;
  } string_cmd_t;

  typedef struct {
    logic [1:0]  action;
    logic [19:0] linear_address;
    logic        access_word;
    logic [15:0] write_data;
    logic [15:0] cur_src_offset;
    logic [15:0] cur_dst_offset;
    logic [15:0] remaining;
  } access_res_t;

  typedef struct {
    string_cmd_t c;
    bit          pinned;
    bit          pin_yields;
    access_res_t r;
  } plan_row_t;

  typedef enum logic [1:0] {
    STAGE_IDLE,
    STAGE_AWAIT_RD,
    STAGE_AWAIT_WR
  } stage_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsmf_in_if  cmd_bus ();
  rsmf_out_if res_bus ();

  rep_string_move_fill_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the sequencer
  logic        fill_mode  = 1'b0;
  logic        word_mode  = 1'b0;
  logic        down_dir   = 1'b0;
  logic [15:0] src_seg    = '0;
  logic [15:0] dst_seg    = '0;
  logic [15:0] src_off    = '0;
  logic [15:0] dst_off    = '0;
  logic [15:0] count_left = '0;
  logic [15:0] data_hold  = '0;
  stage_t      stage      = STAGE_IDLE;

  access_res_t expected_accesses[$];
  plan_row_t   directed_plan[$];
  int          errors = 0;
  int          yielded = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  function automatic logic [19:0] seg_addr(logic [15:0] seg, logic [15:0] off);
    return {seg, 4'h0} + {4'h0, off};
  endfunction

  function automatic logic [15:0] next_off(logic [15:0] off);
    logic [15:0] w;
    w = word_mode ? 16'd2 : 16'd1;
    return down_dir ? off - w : off + w;
  endfunction

  function automatic logic [15:0] keep_width(logic [15:0] d);
    return word_mode ? d : {8'h00, d[7:0]};
  endfunction

  function automatic access_res_t report(logic [1:0] act);
    access_res_t r;
    r = '{default: '0};
    r.action = act;
    if (act == ACT_READ) begin
      r.linear_address = seg_addr(src_seg, src_off);
      r.access_word = word_mode;
    end else if (act == ACT_WRITE) begin
      r.linear_address = seg_addr(dst_seg, dst_off);
      r.access_word = word_mode;
      r.write_data = data_hold;
    end
    r.cur_src_offset = src_off;
    r.cur_dst_offset = dst_off;
    r.remaining = count_left;
    return r;
  endfunction

  function automatic access_res_t next_access();
    if (count_left == 16'd0) begin
      stage = STAGE_IDLE;
      return report(ACT_DONE);
    end else if (fill_mode) begin
      stage = STAGE_AWAIT_WR;
      return report(ACT_WRITE);
    end
    stage = STAGE_AWAIT_RD;
    return report(ACT_READ);
  endfunction

  function automatic bit predict_sequencer_step(string_cmd_t c, output access_res_t r);
    r = '{default: '0};
    case (c.req_type)
      REQ_START: begin
        fill_mode  = c.is_fill;
        word_mode  = c.is_word;
        down_dir   = c.dir_down;
        src_seg    = c.src_segment;
        dst_seg    = c.dst_segment;
        src_off    = c.src_offset;
        dst_off    = c.dst_offset;
        count_left = c.elem_count;
        data_hold  = c.is_fill ? keep_width(c.fill_value) : 16'd0;
        r = next_access();
        return 1'b1;
      end
      REQ_READ_DONE: begin
        if (stage != STAGE_AWAIT_RD) return 1'b0;
        if (c.fault) begin
          stage = STAGE_IDLE;
          r = report(ACT_FAULT);
          return 1'b1;
        end
        data_hold = keep_width(c.read_data);
        stage = STAGE_AWAIT_WR;
        r = report(ACT_WRITE);
        return 1'b1;
      end
      REQ_WRITE_DONE: begin
        if (stage != STAGE_AWAIT_WR) return 1'b0;
        if (c.fault) begin
          stage = STAGE_IDLE;
          r = report(ACT_FAULT);
          return 1'b1;
        end
        if (!fill_mode) src_off = next_off(src_off);
        dst_off = next_off(dst_off);
        count_left = count_left - 16'd1;
        r = next_access();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string_cmd_t mk_start(logic fl, logic wd, logic dn, logic [15:0] sseg,
                                           logic [15:0] dseg, logic [15:0] soff,
                                           logic [15:0] doff, logic [15:0] cnt,
                                           logic [15:0] fv);
    string_cmd_t c;
    c = '{req_type: REQ_START, is_fill: fl, is_word: wd, dir_down: dn, src_segment: sseg,
          dst_segment: dseg, src_offset: soff, dst_offset: doff, elem_count: cnt,
          fill_value: fv, read_data: 16'd0, fault: 1'b0};
    return c;
  endfunction

  function automatic string_cmd_t mk_done(logic [1:0] req, logic [15:0] rd, logic flt);
    string_cmd_t c;
    c = mk_start(1'b0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0);
    c.req_type = req;
    c.read_data = rd;
    c.fault = flt;
    return c;
  endfunction

  function automatic access_res_t mk_res(logic [1:0] act, logic [19:0] addr, logic aw,
                                         logic [15:0] wdat, logic [15:0] so,
                                         logic [15:0] dof, logic [15:0] rem);
    access_res_t r;
    r = '{action: act, linear_address: addr, access_word: aw, write_data: wdat,
          cur_src_offset: so, cur_dst_offset: dof, remaining: rem};
    return r;
  endfunction

  function automatic logic [15:0] pick_offset();
    logic [15:0] corners [4] = '{16'h0000, 16'h0001, 16'hfffe, 16'hffff};
    if ($urandom_range(0, 99) < 20) return corners[2'($urandom_range(0, 3))];
    return 16'($urandom());
  endfunction

  function automatic string_cmd_t random_cmd(bit tidy);
    string_cmd_t c;
    int          r;
    c = mk_start(1'($urandom()), 1'($urandom()), 1'($urandom()), 16'($urandom()),
                 16'($urandom()), pick_offset(), pick_offset(), '0, 16'($urandom()));
    c.read_data = 16'($urandom());
    c.fault = ($urandom_range(0, 99) < 4);
    r = $urandom_range(0, 99);
    c.elem_count = (r < 10) ? 16'd0 : (r < 80) ? 16'($urandom_range(1, 6)) : 16'($urandom());
    if (!tidy) begin
      c.req_type = 2'($urandom_range(0, 3));
      c.fault = 1'($urandom());
    end else if (stage == STAGE_IDLE || $urandom_range(0, 99) < 3) begin
      c.req_type = REQ_START;
    end else begin
      c.req_type = (stage == STAGE_AWAIT_RD) ? REQ_READ_DONE : REQ_WRITE_DONE;
    end
    return c;
  endfunction

  task automatic add_row(string_cmd_t c, bit pinned, bit yields, access_res_t r);
    directed_plan.push_back('{c: c, pinned: pinned, pin_yields: yields, r: r});
  endtask

  task automatic send_cmd(string_cmd_t c, bit pinned, bit pin_yields, access_res_t pin_res);
    access_res_t r;
    bit          y;
    cmd_bus.valid       <= 1'b1;
    cmd_bus.req_type    <= c.req_type;
    cmd_bus.is_fill     <= c.is_fill;
    cmd_bus.is_word     <= c.is_word;
    cmd_bus.dir_down    <= c.dir_down;
    cmd_bus.src_segment <= c.src_segment;
    cmd_bus.dst_segment <= c.dst_segment;
    cmd_bus.src_offset  <= c.src_offset;
    cmd_bus.dst_offset  <= c.dst_offset;
    cmd_bus.elem_count  <= c.elem_count;
    cmd_bus.fill_value  <= c.fill_value;
    cmd_bus.read_data   <= c.read_data;
    cmd_bus.fault       <= c.fault;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    y = predict_sequencer_step(c, r);
    if (pinned) begin
      y = pin_yields;
      r = pin_res;
    end
    if (y) begin
      expected_accesses.push_back(r);
      yielded++;
    end
  endtask

  task automatic sender_gap();
    int r;
    int n;
    if (tx_steady) return;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    cmd_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    wait (expected_accesses.size() == 0);
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [19:0] exp, logic [19:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    access_res_t e;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (expected_accesses.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual action %0d addr 0x%0h",
                 $time, res_bus.action, res_bus.linear_address);
        errors++;
      end else begin
        e = expected_accesses.pop_front();
        check_field("action", 20'(e.action), 20'(res_bus.action));
        check_field("linear_address", e.linear_address, res_bus.linear_address);
        check_field("access_word", 20'(e.access_word), 20'(res_bus.access_word));
        check_field("write_data", 20'(e.write_data), 20'(res_bus.write_data));
        check_field("cur_src_offset", 20'(e.cur_src_offset), 20'(res_bus.cur_src_offset));
        check_field("cur_dst_offset", 20'(e.cur_dst_offset), 20'(res_bus.cur_dst_offset));
        check_field("remaining", 20'(e.remaining), 20'(res_bus.remaining));
      end
    end
  end

  initial begin
    res_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (!rx_steady && $urandom_range(0, 99) < 30) begin
        res_bus.ready <= 1'b0;
        if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(8, 40)) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(200, 800)) @(posedge clk);
      rx_steady <= ~rx_steady;
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    access_res_t none;
    string_cmd_t c;
    int          n;
    none = '{default: '0};
    cmd_bus.valid       = 1'b0;
    cmd_bus.req_type    = REQ_START;
    cmd_bus.is_fill     = 1'b0;
    cmd_bus.is_word     = 1'b0;
    cmd_bus.dir_down    = 1'b0;
    cmd_bus.src_segment = '0;
    cmd_bus.dst_segment = '0;
    cmd_bus.src_offset  = '0;
    cmd_bus.dst_offset  = '0;
    cmd_bus.elem_count  = '0;
    cmd_bus.fill_value  = '0;
    cmd_bus.read_data   = '0;
    cmd_bus.fault       = 1'b0;

    // completions out of turn and the unused code are dropped
    add_row(mk_done(REQ_WRITE_DONE, 16'h0000, 1'b0), 1, 0, none);
    add_row(mk_done(REQ_READ_DONE, 16'hffff, 1'b1), 1, 0, none);
    c = mk_start(1, 1, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    c.req_type = REQ_UNUSED;
    c.read_data = 16'hffff;
    c.fault = 1'b1;
    add_row(c, 1, 0, none);
    // zero count finishes at once
    add_row(mk_start(0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff),
            1, 1, mk_res(ACT_DONE, 20'h0, 0, 16'h0, 16'hffff, 16'hffff, 16'h0));
    // byte fill, address and offset wrap
    add_row(mk_start(1, 0, 0, 16'h0000, 16'hffff, 16'h1357, 16'hffff, 16'h0001, 16'habcd),
            1, 1, mk_res(ACT_WRITE, 20'h0ffef, 0, 16'h00cd, 16'h1357, 16'hffff, 16'h0001));
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0),
            1, 1, mk_res(ACT_DONE, 20'h0, 0, 16'h0, 16'h1357, 16'h0000, 16'h0));
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0), 1, 0, none);
    // word copy, downwards
    add_row(mk_start(0, 1, 1, 16'h1234, 16'h0000, 16'h0001, 16'h0000, 16'h0002, 16'hffff),
            1, 1, mk_res(ACT_READ, 20'h12341, 1, 16'h0, 16'h0001, 16'h0000, 16'h0002));
    add_row(mk_done(REQ_READ_DONE, 16'hffff, 1'b0),
            1, 1, mk_res(ACT_WRITE, 20'h00000, 1, 16'hffff, 16'h0001, 16'h0000, 16'h0002));
    add_row(mk_done(REQ_READ_DONE, 16'h1234, 1'b0), 1, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0),
            1, 1, mk_res(ACT_READ, 20'h2233f, 1, 16'h0, 16'hffff, 16'hfffe, 16'h0001));
    add_row(mk_done(REQ_READ_DONE, 16'h0, 1'b1),
            1, 1, mk_res(ACT_FAULT, 20'h0, 0, 16'h0, 16'hffff, 16'hfffe, 16'h0001));
    add_row(mk_done(REQ_READ_DONE, 16'h0, 1'b0), 1, 0, none);
    // byte copy with masked read data, then restart while busy
    add_row(mk_start(0, 0, 0, 16'h0400, 16'h0800, 16'hfffe, 16'h0001, 16'h0003, 16'h0),
            0, 0, none);
    add_row(mk_done(REQ_READ_DONE, 16'ha5c3, 1'b0), 0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0), 0, 0, none);
    add_row(mk_done(REQ_READ_DONE, 16'h0f0f, 1'b0), 0, 0, none);
    add_row(mk_start(1, 1, 1, 16'h8000, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'hffff),
            0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0), 0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b1), 0, 0, none);
    add_row(mk_start(1, 0, 1, 16'h0000, 16'h7fff, 16'haaaa, 16'h0001, 16'h0002, 16'h5a5a),
            0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0), 0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b0), 0, 0, none);
    add_row(mk_start(0, 1, 0, 16'hffff, 16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'h0),
            0, 0, none);
    add_row(mk_done(REQ_READ_DONE, 16'h00ff, 1'b0), 0, 0, none);
    add_row(mk_done(REQ_WRITE_DONE, 16'h0, 1'b1), 0, 0, none);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      send_cmd(directed_plan[i].c, directed_plan[i].pinned, directed_plan[i].pin_yields,
               directed_plan[i].r);
      sender_gap();
    end
    drain_results();

    n = 0;
    yielded = 0;
    while (yielded < 1800) begin
      if (n % 150 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      c = random_cmd($urandom_range(0, 99) < 88);
      send_cmd(c, 1'b0, 1'b0, none);
      n++;
      if (n % 450 == 0) drain_results();
      else sender_gap();
    end

    cmd_bus.valid <= 1'b0;
    wait (expected_accesses.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
